### design/double_ended_queue_top_macros.svh
// Assertion macros shared by the double-ended queue modules.
// Included by the controller and the datapath; depends on nothing else.
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("double-ended queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("double-ended queue check failed");

`endif

### design/deq_pkg.sv
// Package for the double-ended queue: operation and status codes, controller states,
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package deq_pkg;

   typedef enum logic [2:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_SIZE       = 3'd4,
      FUNC_EMPTY      = 3'd5,
      FUNC_PEEK_FRONT = 3'd6,
      FUNC_PEEK_BACK  = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_READ = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load_read;
   } cmd_type;

   typedef struct packed {
      logic no_result;
      logic needs_read;
   } stat_type;

endpackage

`default_nettype wire

### design/deq_ctrl.sv
// Controller state machine of the double-ended queue.
// Depends on deq_pkg and double_ended_queue_top_macros.svh; drives the datapath commands.
`default_nettype none

`include "double_ended_queue_top_macros.svh"

module deq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire deq_pkg::stat_type stat,
   output deq_pkg::cmd_type       cmd
);

   deq_pkg::state_type state_ff;
   deq_pkg::state_type state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.exec      = 1'b0;
      cmd.load_read = 1'b0;
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      case (state_ff)
         deq_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = deq_pkg::ST_EXEC;
            end
         end
         deq_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.no_result) begin
               state_in = deq_pkg::ST_IDLE;
            end else if (stat.needs_read) begin
               state_in = deq_pkg::ST_READ;
            end else begin
               state_in = deq_pkg::ST_RESP;
            end
         end
         deq_pkg::ST_READ: begin
            cmd.load_read = 1'b1;
            state_in      = deq_pkg::ST_RESP;
         end
         deq_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = deq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= deq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DEQ_ASSERT_NEXT(a_accept_runs, clock, reset, req_valid && !req_stall, state_ff == deq_pkg::ST_EXEC)
   `DEQ_ASSERT_NEXT(a_read_answers, clock, reset, cmd.exec && stat.needs_read, cmd.load_read)

endmodule

`default_nettype wire

### design/deq_dp.sv
// Datapath of the double-ended queue: ring buffer memory, head and occupancy, result registers.
// Depends on deq_pkg and double_ended_queue_top_macros.svh; commanded by deq_ctrl.
`default_nettype none

`include "double_ended_queue_top_macros.svh"

module deq_dp #(
   parameter int DEPTH     = 1024,
   parameter int DATA_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire deq_pkg::cmd_type   cmd,
   output deq_pkg::stat_type       stat,
   input  wire logic        [2:0]  req_func,
   input  wire logic signed [31:0] req_push_value,
   output logic signed      [31:0] rsp_answer,
   output logic             [1:0]  rsp_status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W:0]   DEPTH_SUM  = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_POS   = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic signed [DATA_BITS-1:0] slots_ff [DEPTH];
   logic signed [DATA_BITS-1:0] rd_data_ff;
   logic signed [DATA_BITS-1:0] value_ff;
   deq_pkg::func_type           op_ff;
   logic [PTR_W-1:0]            head_ff;
   logic [PTR_W-1:0]            head_in;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic signed [31:0]          answer_ff;
   logic signed [31:0]          answer_in;
   deq_pkg::status_type         status_ff;
   deq_pkg::status_type         status_in;

   logic signed [63:0] push_wide;
   logic signed [63:0] rd_wide;
   logic               full;
   logic               empty;
   logic               is_push;
   logic               is_read_op;
   logic [PTR_W-1:0]   head_inc;
   logic [PTR_W-1:0]   head_dec;
   logic [PTR_W:0]     back_offset;
   logic [PTR_W:0]     back_sum;
   logic [PTR_W-1:0]   back_pos;
   logic               wr_en;
   logic               rd_en;
   logic [PTR_W-1:0]   mem_addr;

   assign push_wide = 64'(req_push_value);
   assign rd_wide   = 64'(rd_data_ff);

   assign full       = (count_ff == FULL_COUNT);
   assign empty      = (count_ff == '0);
   assign is_push    = (op_ff == deq_pkg::FUNC_PUSH_FRONT) || (op_ff == deq_pkg::FUNC_PUSH_BACK);
   assign is_read_op = (op_ff == deq_pkg::FUNC_POP_FRONT) || (op_ff == deq_pkg::FUNC_POP_BACK)
                    || (op_ff == deq_pkg::FUNC_PEEK_FRONT) || (op_ff == deq_pkg::FUNC_PEEK_BACK);

   assign stat.no_result  = is_push && !full;
   assign stat.needs_read = is_read_op && !empty;

   assign head_inc = (head_ff == LAST_POS) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? LAST_POS : head_ff - 1'b1;

   // The back slot sits one past the last word for a push to the back and on the last word otherwise.
   assign back_offset = (op_ff == deq_pkg::FUNC_PUSH_BACK) ? (PTR_W + 1)'(count_ff)
                                                           : (PTR_W + 1)'(count_ff - 1'b1);
   assign back_sum    = {1'b0, head_ff} + back_offset;
   assign back_pos    = (back_sum >= DEPTH_SUM) ? PTR_W'(back_sum - DEPTH_SUM)
                                                : back_sum[PTR_W-1:0];

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      answer_in = answer_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      mem_addr  = head_ff;
      if (cmd.exec) begin
         case (op_ff)
            deq_pkg::FUNC_PUSH_FRONT: begin
               if (full) begin
                  answer_in = '0;
                  status_in = deq_pkg::STATUS_FULL;
               end else begin
                  head_in  = head_dec;
                  count_in = count_ff + 1'b1;
                  wr_en    = 1'b1;
                  mem_addr = head_dec;
               end
            end
            deq_pkg::FUNC_PUSH_BACK: begin
               if (full) begin
                  answer_in = '0;
                  status_in = deq_pkg::STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
                  wr_en    = 1'b1;
                  mem_addr = back_pos;
               end
            end
            deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_PEEK_FRONT: begin
               if (empty) begin
                  answer_in = '1;
                  status_in = deq_pkg::STATUS_EMPTY;
               end else begin
                  status_in = deq_pkg::STATUS_OK;
                  rd_en     = 1'b1;
                  mem_addr  = head_ff;
                  if (op_ff == deq_pkg::FUNC_POP_FRONT) begin
                     head_in  = head_inc;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            deq_pkg::FUNC_POP_BACK, deq_pkg::FUNC_PEEK_BACK: begin
               if (empty) begin
                  answer_in = '1;
                  status_in = deq_pkg::STATUS_EMPTY;
               end else begin
                  status_in = deq_pkg::STATUS_OK;
                  rd_en     = 1'b1;
                  mem_addr  = back_pos;
                  if (op_ff == deq_pkg::FUNC_POP_BACK) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            deq_pkg::FUNC_SIZE: begin
               answer_in = 32'(count_ff);
               status_in = deq_pkg::STATUS_OK;
            end
            deq_pkg::FUNC_EMPTY: begin
               answer_in = empty ? 32'sd1 : 32'sd0;
               status_in = deq_pkg::STATUS_OK;
            end
            default: begin
               answer_in = answer_ff;
            end
         endcase
      end
      if (cmd.load_read) begin
         answer_in = rd_wide[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[mem_addr] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= slots_ff[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= deq_pkg::func_type'(req_func);
         value_ff <= push_wide[DATA_BITS-1:0];
      end
      answer_ff <= answer_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign rsp_answer = answer_ff;
   assign rsp_status = status_ff;

   `DEQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT)
   `DEQ_ASSERT_NOW(a_head_bound, clock, reset, 1'b1, head_ff <= LAST_POS)
   `DEQ_ASSERT_NEXT(a_count_held, clock, reset, !cmd.exec, $stable(count_ff) && $stable(head_ff))

endmodule

`default_nettype wire

### design/double_ended_queue_top.sv
// Double-ended queue top level: one item at a time through a single-port ring buffer memory.
// A push passes from acceptance through the execute state back to idle and gives no word.
// Size, empty, a push onto a full queue and a pop or peek of an empty queue go from execute
// to response; other pops and peeks pass the read state, for the registered slot memory read.
// At most one item is in flight: the next is taken after the last ends and any word has left.
// Synchronous reset empties the queue; slot contents are not cleared.
`default_nettype none

module double_ended_queue_top #(
   parameter int DEPTH     = 1024,
   parameter int DATA_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic        [2:0]  req_func,
   input  wire logic signed [31:0] req_push_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed      [31:0] rsp_answer,
   output logic             [1:0]  rsp_status
);

   deq_pkg::cmd_type  cmd;
   deq_pkg::stat_type stat;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   deq_dp #(
      .DEPTH     (DEPTH),
      .DATA_BITS (DATA_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_func),
      .req_push_value (req_push_value),
      .rsp_answer     (rsp_answer),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

### tb/sv/double_ended_queue_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue_top: directed table, random mixes and a fill to full.
// Results are checked against a behavioral ring-buffer deque. Depends on deq_pkg.

module double_ended_queue_top_test;

   localparam int QUEUE_DEPTH = 1024;

   typedef struct packed {
      logic [31:0]         answer;
      deq_pkg::status_type status;
   } result_word_type;

   typedef struct packed {
      deq_pkg::func_type   func;
      logic [31:0]         value;
      logic                typed;
      logic [31:0]         answer;
      deq_pkg::status_type status;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic        [2:0]  req_func;
   logic signed [31:0] req_push_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_answer;
   logic        [1:0]  rsp_status;

   logic [31:0]         ring_words [QUEUE_DEPTH];
   int unsigned         front_pos;
   int unsigned         fill_count;
   result_word_type     pending_words [$];
   result_word_type     got_word;
   int                  error_count;
   int                  send_idle_pct;
   int                  rsp_stall_pct;
   logic                typed_pending;
   logic [31:0]         typed_answer;
   deq_pkg::status_type typed_status;
   directed_row_type    directed_rows [22];

   double_ended_queue_top #(
      .DEPTH     (QUEUE_DEPTH),
      .DATA_BITS (32)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_answer     (rsp_answer),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("Some tests failed");
      $finish;
   end

   task automatic predict_item(input deq_pkg::func_type f, input logic [31:0] v);
      int unsigned     slot;
      result_word_type w;
      logic            emits;
      emits    = 1'b1;
      w.answer = '0;
      w.status = deq_pkg::STATUS_OK;
      case (f)
         deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK: begin
            if (fill_count >= QUEUE_DEPTH) begin
               w.status = deq_pkg::STATUS_FULL;
            end else begin
               emits = 1'b0;
               if (f == deq_pkg::FUNC_PUSH_FRONT) begin
                  front_pos = (front_pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                  slot      = front_pos;
               end else begin
                  slot = (front_pos + fill_count) % QUEUE_DEPTH;
               end
               ring_words[slot] = v;
               fill_count++;
            end
         end
         deq_pkg::FUNC_SIZE: w.answer = fill_count;
         deq_pkg::FUNC_EMPTY: w.answer = (fill_count == 0) ? 32'd1 : 32'd0;
         default: begin
            if (fill_count == 0) begin
               w.answer = '1;
               w.status = deq_pkg::STATUS_EMPTY;
            end else begin
               if (f == deq_pkg::FUNC_POP_FRONT || f == deq_pkg::FUNC_PEEK_FRONT) begin
                  slot = front_pos;
               end else begin
                  slot = (front_pos + fill_count - 1) % QUEUE_DEPTH;
               end
               w.answer = ring_words[slot];
               if (f == deq_pkg::FUNC_POP_FRONT) begin
                  front_pos = (front_pos + 1) % QUEUE_DEPTH;
                  fill_count--;
               end else if (f == deq_pkg::FUNC_POP_BACK) begin
                  fill_count--;
               end
            end
         end
      endcase
      if (typed_pending) begin
         emits    = 1'b1;
         w.answer = typed_answer;
         w.status = typed_status;
      end
      if (emits) begin
         pending_words = {pending_words, w};
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               $error("rsp_answer: no word expected, actual %h", rsp_answer);
               error_count++;
            end else begin
               got_word = pending_words[0];
               pending_words.delete(0);
               if (rsp_answer !== got_word.answer) begin
                  $error("rsp_answer mismatch: expected %h, actual %h",
                         got_word.answer, rsp_answer);
                  error_count++;
               end
               if (rsp_status !== got_word.status) begin
                  $error("rsp_status mismatch: expected %0d, actual %0d",
                         got_word.status, rsp_status);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_item(deq_pkg::func_type'(req_func), req_push_value);
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic logic [31:0] random_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input deq_pkg::func_type f, input logic [31:0] v,
                            input logic typed, input logic [31:0] ta,
                            input deq_pkg::status_type ts);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_push_value <= v;
      typed_pending  = typed;
      typed_answer   = ta;
      typed_status   = ts;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic send_random(input int push_pct);
      int                r;
      deq_pkg::func_type f;
      r = $urandom_range(99);
      if (r < push_pct) begin
         f = $urandom_range(1) ? deq_pkg::FUNC_PUSH_BACK : deq_pkg::FUNC_PUSH_FRONT;
      end else if (r < push_pct + (100 - push_pct) * 3 / 4) begin
         f = $urandom_range(1) ? deq_pkg::FUNC_POP_BACK : deq_pkg::FUNC_POP_FRONT;
      end else begin
         case ($urandom_range(3))
            0: f = deq_pkg::FUNC_SIZE;
            1: f = deq_pkg::FUNC_EMPTY;
            2: f = deq_pkg::FUNC_PEEK_FRONT;
            default: f = deq_pkg::FUNC_PEEK_BACK;
         endcase
      end
      send_item(f, random_value(), 1'b0, '0, deq_pkg::STATUS_OK);
   endtask

   task automatic run_mix(input int count);
      int push_pct;
      push_pct = 45;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 75;
               1: push_pct = 45;
               default: push_pct = 15;
            endcase
         end
         send_random(push_pct);
      end
   endtask

   // Sends mostly pushes until the queue holds its full depth, then alternates pushes and other operations.
   task automatic fill_to_full();
      while (fill_count < QUEUE_DEPTH) begin
         send_random(95);
      end
      for (int i = 0; i < 12; i++) begin
         if (i % 2 == 0) begin
            send_random(100);
         end else begin
            send_random(0);
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = deq_pkg::FUNC_SIZE;
      req_push_value = '0;
      rsp_stall      = 1'b0;
      front_pos      = 0;
      fill_count     = 0;
      error_count    = 0;
      send_idle_pct  = 32;
      rsp_stall_pct  = 74;
      typed_pending  = 1'b0;
      typed_answer   = '0;
      typed_status   = deq_pkg::STATUS_OK;
      directed_rows = '{
         '{deq_pkg::FUNC_SIZE,       32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_EMPTY,      32'h0000_0000, 1'b1, 32'h0000_0001, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1, 32'hffff_ffff,
           deq_pkg::STATUS_EMPTY},
         '{deq_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b1, 32'hffff_ffff,
           deq_pkg::STATUS_EMPTY},
         '{deq_pkg::FUNC_PEEK_FRONT, 32'h0000_0000, 1'b1, 32'hffff_ffff,
           deq_pkg::STATUS_EMPTY},
         '{deq_pkg::FUNC_PEEK_BACK,  32'h0000_0000, 1'b1, 32'hffff_ffff,
           deq_pkg::STATUS_EMPTY},
         '{deq_pkg::FUNC_PUSH_BACK,  32'h7fff_ffff, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_PUSH_FRONT, 32'h8000_0000, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_PEEK_FRONT, 32'h0000_0000, 1'b1, 32'h8000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_PEEK_BACK,  32'h0000_0000, 1'b1, 32'h7fff_ffff, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_SIZE,       32'hffff_ffff, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_EMPTY,      32'hffff_ffff, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_PUSH_BACK,  32'hffff_ffff, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_PUSH_FRONT, 32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1, 32'hffff_ffff,
           deq_pkg::STATUS_EMPTY},
         '{deq_pkg::FUNC_PUSH_FRONT, 32'h5a5a_a5a5, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
         '{deq_pkg::FUNC_EMPTY,      32'h0000_0000, 1'b1, 32'h0000_0001, deq_pkg::STATUS_OK}
      };
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].func, directed_rows[i].value, directed_rows[i].typed,
                   directed_rows[i].answer, directed_rows[i].status);
      end
      run_mix(400);

      send_idle_pct = 74;
      rsp_stall_pct = 32;
      fill_to_full();
      run_mix(200);

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_mix(400);
      req_valid <= 1'b0;

      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/deq_pkg.sv
design/deq_ctrl.sv
design/deq_dp.sv
design/double_ended_queue_top.sv
tb/sv/double_ended_queue_top_test.sv
